// ===== src/aflc_pkg.sv =====
`timescale 1ns / 1ps

package aflc_pkg;

	// longest chunk counted before the overflow flag is raised
	localparam logic [8:0] MAX_FRAME = 9'd256;
	localparam logic [8:0] MIN_CHARS = 9'd10;
	localparam logic [8:0] BODY_MAX  = 9'd511;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR     = 2'd1;

	localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd1;
	localparam logic [7:0] START_CHAR_RST     = 8'h3A;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPP_A = 8'h41;
	localparam logic [7:0] CHAR_UPP_F = 8'h46;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_NO_CRLF  = 3'd2;
	localparam logic [2:0] ST_NO_START = 3'd3;
	localparam logic [2:0] ST_BAD_HEX  = 3'd4;
	localparam logic [2:0] ST_ADDR     = 3'd5;
	localparam logic [2:0] ST_LRC      = 3'd6;
	localparam logic [2:0] ST_OVERFLOW = 3'd7;

	typedef struct packed {
		logic [7:0] rx_char;
		logic       frame_end;
	} aflc_in_t;

	typedef struct packed {
		logic       frame_ok;
		logic [2:0] status;
		logic [7:0] station;
		logic [7:0] function_code;
	} aflc_out_t;

	typedef struct packed {
		logic     valid;
		aflc_in_t item;
	} aflc_slot_t;

	// msb set for a character that is not an upper-case hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = c - CHAR_ZERO;
				nibble_of = {1'b0, d[3:0]};
			end else if (c >= CHAR_UPP_A && c <= CHAR_UPP_F) begin
				d = c - CHAR_UPP_A + 8'd10;
				nibble_of = {1'b0, d[3:0]};
			end else begin
				nibble_of = 5'b10000;
			end
		end
	endfunction

endpackage

// ===== src/ascii_frame_lrc_checker.sv =====
`timescale 1ns / 1ps

// ascii frame checker with longitudinal redundancy check
// char channel (char_valid/char_ready/char_data) takes one received character per
// request, with frame_end marking the last character of a chunk
// res channel (res_valid/res_ready/res_data) returns one verdict per chunk:
// frame_ok, status code, station and function bytes
// cfg channel writes device_address (index 0) or start_char (index 1); other
// indexes are dropped; cfg_ready is always high, write only while idle
// throughput: one character per cycle while no last character waits for room,
// set by the single state update path between the input register and the result register
// a last character accepted into the input register moves on into the result register
// once that register is free, and its verdict then shows on res_valid
// characters without frame_end pass through even while a verdict waits; a last
// character is held in the input register until the result register is free,
// so a stalled receiver backs up the char channel by one request
// reset clears all frame state and loads device_address 1 and start_char colon
module ascii_frame_lrc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_ready,
	input  aflc_pkg::aflc_in_t                  char_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output aflc_pkg::aflc_out_t                 res_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aflc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data
);

	aflc_pkg::aflc_slot_t slot;
	aflc_pkg::aflc_out_t  result;
	logic                 advance;
	logic                 out_space;
	logic [7:0]           device_address_q;
	logic [7:0]           start_char_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= aflc_pkg::DEVICE_ADDRESS_RST;
			start_char_q     <= aflc_pkg::START_CHAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aflc_pkg::CFG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				aflc_pkg::CFG_START_CHAR:     start_char_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// only a last character needs room in the result register
	assign advance = slot.valid && (!slot.item.frame_end || out_space);

	aflc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.advance    (advance),
		.slot       (slot)
	);

	aflc_frame_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.slot           (slot),
		.advance        (advance),
		.device_address (device_address_q),
		.start_char     (start_char_q),
		.result         (result)
	);

	aflc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && slot.item.frame_end),
		.result    (result),
		.space     (out_space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

// ===== src/aflc_in_stage.sv =====
`timescale 1ns / 1ps

module aflc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  aflc_pkg::aflc_in_t  char_data,
	input  logic                advance,
	output aflc_pkg::aflc_slot_t slot
);

	logic               valid_s1;
	aflc_pkg::aflc_in_t item_s1;

	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_data;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.item  = item_s1;

endmodule

// ===== src/aflc_frame_state.sv =====
`timescale 1ns / 1ps

module aflc_frame_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aflc_pkg::aflc_slot_t slot,
	input  logic                 advance,
	input  logic [7:0]           device_address,
	input  logic [7:0]           start_char,
	output aflc_pkg::aflc_out_t  result
);

	logic        in_frame_q, in_frame_n;
	logic [8:0]  total_q, total_n;
	logic [8:0]  body_q, body_n;
	logic [3:0]  high_q, high_n;
	logic [7:0]  sum_q, sum_n;
	logic [15:0] prev_q, prev_n;
	logic        hex_err_q, hex_err_n;
	logic [7:0]  addr_q, addr_n;
	logic [7:0]  func_q, func_n;
	logic        ovf_q, ovf_n;
	logic [4:0]  nib;
	logic [7:0]  dec_byte;
	logic [7:0]  c;
	logic [2:0]  status;

	assign c        = slot.item.rx_char;
	assign nib      = aflc_pkg::nibble_of(prev_q[15:8]);
	assign dec_byte = {high_q, nib[3:0]};

	always_comb begin
		in_frame_n = in_frame_q;
		total_n    = total_q;
		body_n     = body_q;
		high_n     = high_q;
		sum_n      = sum_q;
		hex_err_n  = hex_err_q;
		addr_n     = addr_q;
		func_n     = func_q;
		ovf_n      = ovf_q;

		if (total_q >= aflc_pkg::MAX_FRAME) begin
			ovf_n = 1'b1;
		end else begin
			total_n = total_q + 9'd1;
		end

		if (in_frame_q) begin
			// the character two back is decoded, its body index is body_q - 2
			if (body_q >= 9'd2) begin
				if (nib[4]) begin
					hex_err_n = 1'b1;
				end else if (!body_q[0]) begin
					high_n = nib[3:0];
				end else begin
					sum_n = sum_q + dec_byte;
					if (body_q == 9'd3) begin
						addr_n = dec_byte;
					end else if (body_q == 9'd5) begin
						func_n = dec_byte;
					end
				end
			end
			if (body_q < aflc_pkg::BODY_MAX) begin
				body_n = body_q + 9'd1;
			end
		end else if (c == start_char) begin
			in_frame_n = 1'b1;
		end
		prev_n = {prev_q[7:0], c};
	end

	always_comb begin
		priority if (ovf_n) begin
			status = aflc_pkg::ST_OVERFLOW;
		end else if (total_n <= aflc_pkg::MIN_CHARS) begin
			status = aflc_pkg::ST_SHORT;
		end else if (prev_n != {aflc_pkg::CHAR_CR, aflc_pkg::CHAR_LF}) begin
			status = aflc_pkg::ST_NO_CRLF;
		end else if (!in_frame_n) begin
			status = aflc_pkg::ST_NO_START;
		end else if (body_n < aflc_pkg::MIN_CHARS) begin
			status = aflc_pkg::ST_SHORT;
		end else if (hex_err_n || body_n[0]) begin
			status = aflc_pkg::ST_BAD_HEX;
		end else if (addr_n != device_address) begin
			status = aflc_pkg::ST_ADDR;
		end else if (sum_n != 8'd0) begin
			status = aflc_pkg::ST_LRC;
		end else begin
			status = aflc_pkg::ST_OK;
		end
	end

	assign result.frame_ok      = (status == aflc_pkg::ST_OK);
	assign result.status        = status;
	assign result.station       = addr_n;
	assign result.function_code = func_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			total_q    <= '0;
			body_q     <= '0;
			high_q     <= '0;
			sum_q      <= '0;
			prev_q     <= '0;
			hex_err_q  <= 1'b0;
			addr_q     <= '0;
			func_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (advance) begin
			if (slot.item.frame_end) begin
				in_frame_q <= 1'b0;
				total_q    <= '0;
				body_q     <= '0;
				high_q     <= '0;
				sum_q      <= '0;
				prev_q     <= '0;
				hex_err_q  <= 1'b0;
				addr_q     <= '0;
				func_q     <= '0;
				ovf_q      <= 1'b0;
			end else begin
				in_frame_q <= in_frame_n;
				total_q    <= total_n;
				body_q     <= body_n;
				high_q     <= high_n;
				sum_q      <= sum_n;
				prev_q     <= prev_n;
				hex_err_q  <= hex_err_n;
				addr_q     <= addr_n;
				func_q     <= func_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && slot.item.frame_end |=> !in_frame_q && total_q == '0 && body_q == '0)
		else $error("frame state not cleared after last character");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= aflc_pkg::MAX_FRAME)
		else $error("character count beyond frame limit");

	a_ovf_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> total_q == aflc_pkg::MAX_FRAME)
		else $error("overflow flag without full count");

	a_body_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		body_q != '0 |-> in_frame_q)
		else $error("body counted before start character");

endmodule

// ===== src/aflc_out_stage.sv =====
`timescale 1ns / 1ps

module aflc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  aflc_pkg::aflc_out_t result,
	output logic                space,
	output logic                res_valid,
	input  logic                res_ready,
	output aflc_pkg::aflc_out_t res_data
);

	logic                valid_q;
	aflc_pkg::aflc_out_t data_q;

	assign space     = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import aflc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_CHARS = 220;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_B = 2'd3;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;

	class frame_judge;
		aflc_out_t verdicts_due[$];
		int errors;
		int checked;
		int status_seen[8];
		logic [7:0] station_addr;
		logic [7:0] open_char;
		logic       in_frame;
		logic [8:0] total_cnt;
		logic [8:0] body_cnt;
		logic [3:0] hi_nib;
		logic [7:0] lrc_sum;
		logic [15:0] prev_two;
		logic       hex_bad;
		logic [7:0] addr;
		logic [7:0] func;
		logic       ovf;

		function new();
			station_addr = DEVICE_ADDRESS_RST;
			open_char = START_CHAR_RST;
			errors = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			in_frame = 1'b0;
			total_cnt = '0;
			body_cnt = '0;
			hi_nib = '0;
			lrc_sum = '0;
			prev_two = '0;
			hex_bad = 1'b0;
			addr = '0;
			func = '0;
			ovf = 1'b0;
		endfunction

		function void take_write(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
			if (idx == CFG_DEVICE_ADDRESS)
				station_addr = val;
			else if (idx == CFG_START_CHAR)
				open_char = val;
		endfunction

		// upper-case hex only, bit 4 flags anything else
		function logic [4:0] digit_value(logic [7:0] ch);
			if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
				return {1'b0, ch[3:0]};
			if (ch >= CHAR_UPP_A && ch <= CHAR_UPP_F)
				return {1'b0, ch[3:0] + 4'd9};
			return 5'b10000;
		endfunction

		function void take_char(aflc_in_t c);
			logic [4:0] nib;
			logic [8:0] pos;
			logic [7:0] b;
			logic [2:0] st;
			aflc_out_t v;
			if (total_cnt >= MAX_FRAME)
				ovf = 1'b1;
			else
				total_cnt = total_cnt + 9'd1;
			if (in_frame) begin
				// body decoded two characters late so the closing cr lf is never decoded
				if (body_cnt >= 9'd2) begin
					pos = body_cnt - 9'd2;
					nib = digit_value(prev_two[15:8]);
					if (nib[4]) begin
						hex_bad = 1'b1;
					end else if (!pos[0]) begin
						hi_nib = nib[3:0];
					end else begin
						b = {hi_nib, nib[3:0]};
						lrc_sum = lrc_sum + b;
						if (pos == 9'd1)
							addr = b;
						else if (pos == 9'd3)
							func = b;
					end
				end
				if (body_cnt < BODY_MAX)
					body_cnt = body_cnt + 9'd1;
			end else if (c.rx_char == open_char) begin
				in_frame = 1'b1;
			end
			prev_two = {prev_two[7:0], c.rx_char};
			if (!c.frame_end)
				return;
			if (ovf)
				st = ST_OVERFLOW;
			else if (total_cnt <= MIN_CHARS)
				st = ST_SHORT;
			else if (prev_two != {CHAR_CR, CHAR_LF})
				st = ST_NO_CRLF;
			else if (!in_frame)
				st = ST_NO_START;
			else if (body_cnt < MIN_CHARS)
				st = ST_SHORT;
			else if (hex_bad || body_cnt[0])
				st = ST_BAD_HEX;
			else if (addr != station_addr)
				st = ST_ADDR;
			else if (lrc_sum != 8'd0)
				st = ST_LRC;
			else
				st = ST_OK;
			v.frame_ok = (st == ST_OK);
			v.status = st;
			v.station = addr;
			v.function_code = func;
			verdicts_due.push_back(v);
			clear_frame();
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_verdict(aflc_out_t got);
			aflc_out_t want;
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("verdict %h with none outstanding", got));
				return;
			end
			want = verdicts_due.pop_front();
			checked++;
			status_seen[want.status]++;
			if (got.frame_ok !== want.frame_ok)
				report_mismatch($sformatf("frame_ok %b, want %b", got.frame_ok, want.frame_ok));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.station !== want.station)
				report_mismatch($sformatf("station %h, want %h", got.station, want.station));
			if (got.function_code !== want.function_code)
				report_mismatch($sformatf("function_code %h, want %h",
					got.function_code, want.function_code));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic char_valid;
	logic char_ready;
	aflc_in_t char_data;
	logic res_valid;
	logic res_ready;
	aflc_out_t res_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	frame_judge judge;
	logic [7:0] chunk_q[$];
	int idle_pct = 6;
	bit hold_req = 1'b0;
	int cycles = 0;
	int n_chars = 0;
	int n_chunks = 0;
	int n_settings = 1;

	ascii_frame_lrc_checker uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data(char_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycles, judge.pending());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			judge.check_verdict(res_data);
	end

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				res_ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 4'd10) ? CHAR_ZERO + {4'd0, n} : CHAR_UPP_A + {4'd0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] non_start_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		while (ch == judge.open_char)
			ch = 8'($urandom_range(0, 255));
		return ch;
	endfunction

	// junk prefix, start char, address, function, data, lrc, cr lf
	function automatic void make_frame(int n_data, int pre_len, bit good_addr, bit good_lrc);
		logic [7:0] bytes_q[$];
		logic [7:0] sum;
		chunk_q.delete();
		repeat (pre_len) chunk_q.push_back(non_start_char());
		chunk_q.push_back(judge.open_char);
		bytes_q.push_back(good_addr ? judge.station_addr : 8'($urandom_range(0, 255)));
		repeat (n_data + 1) bytes_q.push_back(8'($urandom_range(0, 255)));
		sum = '0;
		foreach (bytes_q[i]) sum = sum + bytes_q[i];
		if (good_lrc)
			bytes_q.push_back(~sum + 8'd1);
		else
			bytes_q.push_back(~sum + 8'd1 + 8'($urandom_range(1, 255)));
		foreach (bytes_q[i]) begin
			chunk_q.push_back(hex_char(bytes_q[i][7:4]));
			chunk_q.push_back(hex_char(bytes_q[i][3:0]));
		end
		chunk_q.push_back(CHAR_CR);
		chunk_q.push_back(CHAR_LF);
	endfunction

	function automatic void random_chunk();
		int r;
		int n;
		int lo;
		int pos;
		r = $urandom_range(0, 99);
		if (r >= 89) begin
			chunk_q.delete();
			repeat ($urandom_range(1, 20)) chunk_q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1)) begin
				chunk_q.push_back(CHAR_CR);
				chunk_q.push_back(CHAR_LF);
			end
			return;
		end
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
		make_frame(n, $urandom_range(0, 3), $urandom_range(0, 9) != 0,
			$urandom_range(0, 9) != 0);
		lo = chunk_q.size() - 2 - 2 * (n + 3);
		pos = $urandom_range(lo, chunk_q.size() - 3);
		if (r >= 60 && r < 75) begin
			case ($urandom_range(0, 3))
				0: chunk_q[pos] = CHAR_LOW_A + 8'($urandom_range(0, 5));
				1: chunk_q[pos] = CHAR_UPP_F + 8'd1;
				2: chunk_q[pos] = 8'($urandom_range(0, 255));
				default: chunk_q[pos] = judge.open_char;
			endcase
		end else if (r >= 75 && r < 83) begin
			// odd number of hex characters
			chunk_q.delete(pos);
		end else if (r >= 83) begin
			case ($urandom_range(0, 2))
				0: chunk_q[chunk_q.size() - 1] = 8'($urandom_range(0, 255));
				1: chunk_q[chunk_q.size() - 2] = 8'($urandom_range(0, 255));
				default: chunk_q.delete(chunk_q.size() - 1);
			endcase
		end
	endfunction

	// starts and ends at a falling edge, valid left high after the last request
	task send_chunk();
		aflc_in_t c;
		for (int i = 0; i < chunk_q.size(); i++) begin
			c.rx_char = chunk_q[i];
			c.frame_end = (i == chunk_q.size() - 1);
			while ($urandom_range(0, 99) < idle_pct) begin
				char_valid <= 1'b0;
				@(negedge clk);
			end
			char_valid <= 1'b1;
			char_data <= c;
			@(posedge clk);
			while (!char_ready) @(posedge clk);
			judge.take_char(c);
			n_chars++;
			@(negedge clk);
		end
		n_chunks++;
	endtask

	task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		judge.take_write(idx, val);
		@(negedge clk);
	endtask

	task wait_idle();
		while (judge.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int base;
		int k;
		logic [7:0] a;
		logic [7:0] s;
		judge = new();
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEVICE_ADDRESS;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// shortest passing frame, a one-character chunk, a frame with no start
		make_frame(0, 0, 1, 1);
		chunk_q.insert(chunk_q.size() - 2, hex_char(4'h0));
		chunk_q.insert(chunk_q.size() - 2, hex_char(4'h0));
		send_chunk();
		chunk_q.delete();
		chunk_q.push_back(8'hFF);
		send_chunk();
		chunk_q.delete();
		repeat (9) chunk_q.push_back(8'h00);
		chunk_q.push_back(CHAR_CR);
		chunk_q.push_back(CHAR_LF);
		send_chunk();

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				char_valid <= 1'b0;
				wait_idle();
				case (p)
					1: begin a = 8'h00; s = 8'h00; end
					2: begin a = 8'hFF; s = 8'hFF; end
					3: begin
						a = 8'($urandom_range(0, 255));
						s = 8'($urandom_range(0, 255));
					end
					default: begin a = DEVICE_ADDRESS_RST; s = START_CHAR_RST; end
				endcase
				write_reg(CFG_DEVICE_ADDRESS, a);
				write_reg(CFG_START_CHAR, s);
				if (p == 2)
					write_reg(CFG_UNUSED_A, 8'($urandom_range(0, 255)));
				if (p == 3)
					write_reg(CFG_UNUSED_B, 8'($urandom_range(0, 255)));
				cfg_valid <= 1'b0;
				n_settings++;
			end
			idle_pct = (p == 2) ? 0 : 6;
			if (p == 3)
				hold_req = 1'b1;
			base = n_chars;
			k = 0;
			while (n_chars - base < PHASE_CHARS) begin
				// exactly the frame limit, then one character over it
				if (p == 1 && k == 3)
					make_frame(123, 1, 1, 1);
				else if (p == 4 && k == 3)
					make_frame(124, 0, 1, 1);
				else
					random_chunk();
				send_chunk();
				k++;
			end
		end
		char_valid <= 1'b0;
		wait_idle();

		$display("sent %0d characters in %0d chunks under %0d register settings, %0d verdicts",
			n_chars, n_chunks, n_settings, judge.checked);
		$display("verdicts ok %0d short %0d crlf %0d start %0d hex %0d addr %0d lrc %0d ovf %0d",
			judge.status_seen[ST_OK], judge.status_seen[ST_SHORT],
			judge.status_seen[ST_NO_CRLF], judge.status_seen[ST_NO_START],
			judge.status_seen[ST_BAD_HEX], judge.status_seen[ST_ADDR],
			judge.status_seen[ST_LRC], judge.status_seen[ST_OVERFLOW]);
		if (judge.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/aflc_pkg.sv
src/aflc_in_stage.sv
src/aflc_frame_state.sv
src/aflc_out_stage.sv
src/ascii_frame_lrc_checker.sv
bench/tb.sv
